/* src/luma_deblock_edge_line_filter_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the luma deblocking edge line filter.
// Shared shorthand for clocked properties with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef LUMA_DEBLOCK_EDGE_LINE_FILTER_TOP_ASSERT_SVH
`define LUMA_DEBLOCK_EDGE_LINE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LDF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ldf assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ldf assertion failed");

`endif

/* src/ldf_pkg.sv */
// ----------------------------------------------------------------------------
// ldf_pkg
// Types, codes and helpers shared by the luma deblocking edge line filter.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int SAMPLE_W = 8;
  localparam int CLIP_W   = 5;
  localparam int CFG_IDX_W = 2;

  // Filter mode codes carried by each item.
  localparam logic MODE_STRONG = 1'b0;
  localparam logic MODE_NORMAL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP  = 2'd2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // One line of samples across the edge.
  typedef struct packed {
    sample_t p3;
    sample_t p2;
    sample_t p1;
    sample_t p0;
    sample_t q0;
    sample_t q1;
    sample_t q2;
    sample_t q3;
  } ldf_samples_t;

  // Decisions taken by the edge test.
  typedef struct packed {
    logic mode;
    logic edge_pass;
    logic p_flat;
    logic q_flat;
    logic step_small;
  } ldf_check_t;

  typedef struct packed {
    ldf_check_t   chk;
    ldf_samples_t smp;
  } ldf_check_item_t;

  // Candidate values for every branch of the filter.
  typedef struct packed {
    ldf_check_t        chk;
    ldf_samples_t      smp;
    sample_t           strong_p0;
    sample_t           strong_p1;
    sample_t           strong_p2;
    sample_t           weak_p0;
    sample_t           strong_q0;
    sample_t           strong_q1;
    sample_t           strong_q2;
    sample_t           weak_q0;
    sample_t           adj_p1;
    sample_t           adj_q1;
    logic signed [8:0] delta;
    logic [5:0]        tc;
  } ldf_tap_item_t;

  typedef struct packed {
    sample_t new_p2;
    sample_t new_p1;
    sample_t new_p0;
    sample_t new_q0;
    sample_t new_q1;
    sample_t new_q2;
    logic    edge_filtered;
  } ldf_result_t;

  // Absolute difference of two samples.
  function automatic sample_t ldf_abs_diff(input sample_t a, input sample_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* src/ldf_if.sv */
// ----------------------------------------------------------------------------
// ldf channel interfaces
// Sample line input, filtered line output and configuration write channel.
// ----------------------------------------------------------------------------
interface ldf_in_if;
  import ldf_pkg::*;

  logic    valid;
  logic    ready;
  logic    filter_mode;
  sample_t sample_p3;
  sample_t sample_p2;
  sample_t sample_p1;
  sample_t sample_p0;
  sample_t sample_q0;
  sample_t sample_q1;
  sample_t sample_q2;
  sample_t sample_q3;

  modport source (
    output valid, filter_mode, sample_p3, sample_p2, sample_p1, sample_p0,
           sample_q0, sample_q1, sample_q2, sample_q3,
    input  ready
  );
  modport sink (
    input  valid, filter_mode, sample_p3, sample_p2, sample_p1, sample_p0,
           sample_q0, sample_q1, sample_q2, sample_q3,
    output ready
  );
endinterface

interface ldf_out_if;
  import ldf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t new_p2;
  sample_t new_p1;
  sample_t new_p0;
  sample_t new_q0;
  sample_t new_q1;
  sample_t new_q2;
  logic    edge_filtered;

  modport source (
    output valid, new_p2, new_p1, new_p0, new_q0, new_q1, new_q2, edge_filtered,
    input  ready
  );
  modport sink (
    input  valid, new_p2, new_p1, new_p0, new_q0, new_q1, new_q2, edge_filtered,
    output ready
  );
endinterface

interface ldf_cfg_if;
  import ldf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/ldf_edge_check.sv */
// ----------------------------------------------------------------------------
// ldf_edge_check
// First stage: alpha/beta edge test and the flatness decisions, registered
// together with the sample line.
// ----------------------------------------------------------------------------
module ldf_edge_check (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              alpha_limit,
  input  logic [7:0]              beta_limit,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  ldf_pkg::ldf_samples_t   in_smp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ldf_pkg::ldf_check_item_t out_item
);
  import ldf_pkg::*;

  sample_t         d_p0q0;
  sample_t         d_p1p0;
  sample_t         d_q1q0;
  sample_t         d_p2p0;
  sample_t         d_q2q0;
  sample_t         near_limit;
  ldf_check_t      chk_next;
  logic            valid;
  ldf_check_item_t item;

  // Gradients across and beside the edge.
  always_comb begin
    d_p0q0 = ldf_abs_diff(in_smp.p0, in_smp.q0);
    d_p1p0 = ldf_abs_diff(in_smp.p1, in_smp.p0);
    d_q1q0 = ldf_abs_diff(in_smp.q1, in_smp.q0);
    d_p2p0 = ldf_abs_diff(in_smp.p2, in_smp.p0);
    d_q2q0 = ldf_abs_diff(in_smp.q2, in_smp.q0);
    near_limit = {2'b00, alpha_limit[7:2]} + 8'd2;
    chk_next.mode       = in_mode;
    chk_next.edge_pass  = (d_p0q0 < alpha_limit) && (d_p1p0 < beta_limit) &&
                          (d_q1q0 < beta_limit);
    chk_next.p_flat     = d_p2p0 < beta_limit;
    chk_next.q_flat     = d_q2q0 < beta_limit;
    chk_next.step_small = d_p0q0 < near_limit;
  end

  // The stage takes a new item whenever it is empty or drains this cycle.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.chk <= chk_next;
      item.smp <= in_smp;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

/* src/ldf_tap_calc.sv */
// ----------------------------------------------------------------------------
// ldf_tap_calc
// Second stage: strong smoothing taps, weak taps, clipped p1/q1 moves and the
// raw normal-mode delta.
// ----------------------------------------------------------------------------
module ldf_tap_calc (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [4:0]               clip_base,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ldf_pkg::ldf_check_item_t in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ldf_pkg::ldf_tap_item_t   out_item
);
  import ldf_pkg::*;

  `include "luma_deblock_edge_line_filter_top_assert.svh"

  sample_t           p3, p2, p1, p0, q0, q1, q2, q3;
  logic [10:0]       sum_sp0, sum_sp2, sum_sq0, sum_sq2;
  logic [9:0]        sum_sp1, sum_wp0, sum_sq1, sum_wq0;
  logic [8:0]        avg_sum;
  sample_t           avg;
  logic [8:0]        half_p, half_q;
  logic signed [9:0] move_p, move_q, clip_p, clip_q, tc0_s;
  logic signed [11:0] raw;
  ldf_tap_item_t     item_next;
  logic              valid;
  ldf_tap_item_t     item;

  always_comb begin
    p3 = in_item.smp.p3;
    p2 = in_item.smp.p2;
    p1 = in_item.smp.p1;
    p0 = in_item.smp.p0;
    q0 = in_item.smp.q0;
    q1 = in_item.smp.q1;
    q2 = in_item.smp.q2;
    q3 = in_item.smp.q3;
  end

  // Strong mode 4- and 5-tap sums and the weak 3-tap sums.
  always_comb begin
    sum_sp0 = 11'(p2) + (11'(p1) << 1) + (11'(p0) << 1) + (11'(q0) << 1) +
              11'(q1) + 11'd4;
    sum_sp1 = 10'(p2) + 10'(p1) + 10'(p0) + 10'(q0) + 10'd2;
    sum_sp2 = (11'(p3) << 1) + 11'(p2) + (11'(p2) << 1) + 11'(p1) + 11'(p0) +
              11'(q0) + 11'd4;
    sum_wp0 = (10'(p1) << 1) + 10'(p0) + 10'(q1) + 10'd2;
    sum_sq0 = 11'(p1) + (11'(p0) << 1) + (11'(q0) << 1) + (11'(q1) << 1) +
              11'(q2) + 11'd4;
    sum_sq1 = 10'(p0) + 10'(q0) + 10'(q1) + 10'(q2) + 10'd2;
    sum_sq2 = (11'(q3) << 1) + 11'(q2) + (11'(q2) << 1) + 11'(q1) + 11'(q0) +
              11'(p0) + 11'd4;
    sum_wq0 = (10'(q1) << 1) + 10'(q0) + 10'(p1) + 10'd2;
  end

  // Normal mode: p1/q1 pulled toward the midpoint, limited to tc0.
  always_comb begin
    avg_sum = 9'(p0) + 9'(q0) + 9'd1;
    avg     = avg_sum[8:1];
    half_p  = 9'(p2) + 9'(avg);
    half_q  = 9'(q2) + 9'(avg);
    move_p  = $signed({2'b00, half_p[8:1]}) - $signed({2'b00, p1});
    move_q  = $signed({2'b00, half_q[8:1]}) - $signed({2'b00, q1});
    tc0_s   = $signed({5'b00000, clip_base});
    if (move_p > tc0_s) begin
      clip_p = tc0_s;
    end else if (move_p < -tc0_s) begin
      clip_p = -tc0_s;
    end else begin
      clip_p = move_p;
    end
    if (move_q > tc0_s) begin
      clip_q = tc0_s;
    end else if (move_q < -tc0_s) begin
      clip_q = -tc0_s;
    end else begin
      clip_q = move_q;
    end
  end

  // Raw edge delta; the arithmetic shift by three floors negative values.
  always_comb begin
    raw = ($signed({4'b0000, q0}) <<< 2) - ($signed({4'b0000, p0}) <<< 2) +
          $signed({4'b0000, p1}) - $signed({4'b0000, q1}) + 12'sd4;
  end

  always_comb begin
    item_next.chk       = in_item.chk;
    item_next.smp       = in_item.smp;
    item_next.strong_p0 = sum_sp0[10:3];
    item_next.strong_p1 = sum_sp1[9:2];
    item_next.strong_p2 = sum_sp2[10:3];
    item_next.weak_p0   = sum_wp0[9:2];
    item_next.strong_q0 = sum_sq0[10:3];
    item_next.strong_q1 = sum_sq1[9:2];
    item_next.strong_q2 = sum_sq2[10:3];
    item_next.weak_q0   = sum_wq0[9:2];
    item_next.adj_p1    = 8'($signed({2'b00, p1}) + clip_p);
    item_next.adj_q1    = 8'($signed({2'b00, q1}) + clip_q);
    item_next.delta     = raw[11:3];
    item_next.tc        = 6'(clip_base) + 6'(in_item.chk.p_flat) +
                          6'(in_item.chk.q_flat);
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

  // A stalled stage keeps its item untouched.
  `LDF_ASSERT_NEXT(a_tap_hold, clk, rst, valid && !out_ready, valid && $stable(item))

endmodule

/* src/ldf_select.sv */
// ----------------------------------------------------------------------------
// ldf_select
// Third stage: chooses between the filter branches, clips the delta to tc,
// clips new p0/q0 to the sample range and holds the result item.
// ----------------------------------------------------------------------------
module ldf_select (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ldf_pkg::ldf_tap_item_t in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ldf_pkg::ldf_result_t   out_res
);
  import ldf_pkg::*;

  `include "luma_deblock_edge_line_filter_top_assert.svh"

  logic signed [8:0] tc_s;
  logic signed [8:0] dclip;
  logic signed [9:0] sum_p0, sum_q0;
  sample_t           norm_p0, norm_q0;
  logic              use_p_strong, use_q_strong;
  ldf_result_t       res_next;
  logic              valid;
  ldf_result_t       res;
  logic              accept;

  // Delta limited to tc, then applied and clipped to 0..255.
  always_comb begin
    tc_s = $signed({3'b000, in_item.tc});
    if (in_item.delta > tc_s) begin
      dclip = tc_s;
    end else if (in_item.delta < -tc_s) begin
      dclip = -tc_s;
    end else begin
      dclip = in_item.delta;
    end
    sum_p0 = $signed({2'b00, in_item.smp.p0}) + 10'(dclip);
    sum_q0 = $signed({2'b00, in_item.smp.q0}) - 10'(dclip);
    if (sum_p0 < 10'sd0) begin
      norm_p0 = '0;
    end else if (sum_p0 > $signed({2'b00, SAMPLE_MAX})) begin
      norm_p0 = SAMPLE_MAX;
    end else begin
      norm_p0 = sum_p0[7:0];
    end
    if (sum_q0 < 10'sd0) begin
      norm_q0 = '0;
    end else if (sum_q0 > $signed({2'b00, SAMPLE_MAX})) begin
      norm_q0 = SAMPLE_MAX;
    end else begin
      norm_q0 = sum_q0[7:0];
    end
  end

  // Branch selection; untouched samples pass through.
  always_comb begin
    use_p_strong = in_item.chk.step_small && in_item.chk.p_flat;
    use_q_strong = in_item.chk.step_small && in_item.chk.q_flat;
    res_next.new_p2        = in_item.smp.p2;
    res_next.new_p1        = in_item.smp.p1;
    res_next.new_p0        = in_item.smp.p0;
    res_next.new_q0        = in_item.smp.q0;
    res_next.new_q1        = in_item.smp.q1;
    res_next.new_q2        = in_item.smp.q2;
    res_next.edge_filtered = in_item.chk.edge_pass;
    if (in_item.chk.edge_pass) begin
      if (in_item.chk.mode == MODE_STRONG) begin
        if (use_p_strong) begin
          res_next.new_p0 = in_item.strong_p0;
          res_next.new_p1 = in_item.strong_p1;
          res_next.new_p2 = in_item.strong_p2;
        end else begin
          res_next.new_p0 = in_item.weak_p0;
        end
        if (use_q_strong) begin
          res_next.new_q0 = in_item.strong_q0;
          res_next.new_q1 = in_item.strong_q1;
          res_next.new_q2 = in_item.strong_q2;
        end else begin
          res_next.new_q0 = in_item.weak_q0;
        end
      end else begin
        if (in_item.chk.p_flat) begin
          res_next.new_p1 = in_item.adj_p1;
        end
        if (in_item.chk.q_flat) begin
          res_next.new_q1 = in_item.adj_q1;
        end
        res_next.new_p0 = norm_p0;
        res_next.new_q0 = norm_q0;
      end
    end
  end

  assign in_ready = !valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign out_valid = valid;
  assign out_res   = res;

  // An item taken in is offered at the output on the next cycle.
  `LDF_ASSERT_NEXT(a_sel_offer, clk, rst, accept, valid)
  // Normal mode never changes p2 or q2.
  `LDF_ASSERT_NEXT(a_sel_normal_outer, clk, rst, accept && in_item.chk.mode == MODE_NORMAL, res.new_p2 == $past(in_item.smp.p2) && res.new_q2 == $past(in_item.smp.q2))
  // A failed edge test leaves the line untouched and unflagged.
  `LDF_ASSERT_NEXT(a_sel_bypass, clk, rst, accept && !in_item.chk.edge_pass, !res.edge_filtered && res.new_p0 == $past(in_item.smp.p0) && res.new_q0 == $past(in_item.smp.q0))

endmodule

/* src/luma_deblock_edge_line_filter_top.sv */
// ----------------------------------------------------------------------------
// luma_deblock_edge_line_filter_top
// Deblocking filter for one line of eight luma samples across a block edge.
//
//   Channel   Direction  Carries
//   in_chan   sink       filter_mode, sample_p3 .. sample_q3
//   out_chan  source     new_p2 .. new_q2, edge_filtered
//   cfg_chan  sink       index, data (alpha_limit, beta_limit, clip_base)
//
// Every item passes three register stages in order: edge test, tap sums,
// and select and clip.
// One item per cycle is sustained while the output is ready; each stage holds one item.
// A stalled output holds its item, and each stage takes a new item as soon
// as it is empty or its item moves on, so bubbles close up.
// Synchronous reset empties the pipeline and clears the limits to zero.
// The configuration channel is always ready and its writes are registered.
// ----------------------------------------------------------------------------
module luma_deblock_edge_line_filter_top (
  input  logic       clk,
  input  logic       rst,
  ldf_in_if.sink     in_chan,
  ldf_out_if.source  out_chan,
  ldf_cfg_if.sink    cfg_chan
);
  import ldf_pkg::*;

  logic [SAMPLE_W-1:0] alpha_limit;
  logic [SAMPLE_W-1:0] beta_limit;
  logic [CLIP_W-1:0]   clip_base;
  ldf_samples_t        in_smp;
  logic                chk_valid, chk_ready;
  ldf_check_item_t     chk_item;
  logic                tap_valid, tap_ready;
  ldf_tap_item_t       tap_item;
  ldf_result_t         res;

  // Configuration registers.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_limit <= '0;
      beta_limit  <= '0;
      clip_base   <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        CFG_ALPHA: alpha_limit <= cfg_chan.data;
        CFG_BETA:  beta_limit  <= cfg_chan.data;
        CFG_CLIP:  clip_base   <= cfg_chan.data[CLIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Gather the sample line.
  always_comb begin
    in_smp.p3 = in_chan.sample_p3;
    in_smp.p2 = in_chan.sample_p2;
    in_smp.p1 = in_chan.sample_p1;
    in_smp.p0 = in_chan.sample_p0;
    in_smp.q0 = in_chan.sample_q0;
    in_smp.q1 = in_chan.sample_q1;
    in_smp.q2 = in_chan.sample_q2;
    in_smp.q3 = in_chan.sample_q3;
  end

  ldf_edge_check u_check (
    .clk         (clk),
    .rst         (rst),
    .alpha_limit (alpha_limit),
    .beta_limit  (beta_limit),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_mode     (in_chan.filter_mode),
    .in_smp      (in_smp),
    .out_valid   (chk_valid),
    .out_ready   (chk_ready),
    .out_item    (chk_item)
  );

  ldf_tap_calc u_taps (
    .clk       (clk),
    .rst       (rst),
    .clip_base (clip_base),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_item   (chk_item),
    .out_valid (tap_valid),
    .out_ready (tap_ready),
    .out_item  (tap_item)
  );

  ldf_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tap_valid),
    .in_ready  (tap_ready),
    .in_item   (tap_item),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  // Drive the result fields.
  assign out_chan.new_p2        = res.new_p2;
  assign out_chan.new_p1        = res.new_p1;
  assign out_chan.new_p0        = res.new_p0;
  assign out_chan.new_q0        = res.new_q0;
  assign out_chan.new_q1        = res.new_q1;
  assign out_chan.new_q2        = res.new_q2;
  assign out_chan.edge_filtered = res.edge_filtered;

endmodule
